[rtl/core/soag_pkg.sv]
// ----------------------------------------------------------------------------
// soag_pkg
// Shared widths, register indexes and types of the spiral order address
// generator.
// ----------------------------------------------------------------------------
package soag_pkg;

	localparam int MAX_SIZE = 64;
	localparam int SIZE_W   = 7;
	localparam int COORD_W  = 6;
	localparam int COUNT_W  = 13;
	localparam int BOUND_W  = SIZE_W + 1;
	localparam int CFG_W    = SIZE_W;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_MATRIX_SIZE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_CORNER   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TURN_DIRECTION = 2'd2;

	typedef enum logic [1:0] {
		EDGE_TOP    = 2'd0,
		EDGE_RIGHT  = 2'd1,
		EDGE_BOTTOM = 2'd2,
		EDGE_LEFT   = 2'd3
	} edge_t;

	typedef logic signed [BOUND_W-1:0] bound_t;

	typedef struct packed {
		bound_t row;
		bound_t col;
	} pos_t;

endpackage

[rtl/core/soag_if.sv]
// ----------------------------------------------------------------------------
// soag_req_if / soag_cell_if
// Valid/ready channels of the spiral order address generator: the request
// channel carries the restart flag, the cell channel one emitted cell.
// ----------------------------------------------------------------------------
interface soag_req_if;
	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink (input valid, input restart, output ready);
endinterface

interface soag_cell_if
	import soag_pkg::*;
;
	logic               valid;
	logic               ready;
	logic [COORD_W-1:0] row;
	logic [COORD_W-1:0] column;
	logic [COUNT_W-1:0] order_number;
	logic               last_cell;

	modport source (output valid, output row, output column, output order_number,
		output last_cell, input ready);
	modport sink (input valid, input row, input column, input order_number,
		input last_cell, output ready);
endinterface

[rtl/core/spiral_order_address_generator_top.sv]
// ----------------------------------------------------------------------------
// spiral_order_address_generator_top
// Emits the cells of a square matrix in spiral order, one cell per beat.
// ----------------------------------------------------------------------------
// The block takes one request beat per clock while the sink does not stall
// and answers it from a single result register, so a steady stream of advance
// beats yields one cell per cycle while the sink takes them, each cell showing
// in the cycle after its beat; the only limit is the result register, which
// holds a cell while the sink stalls and still frees up in the same cycle that
// the sink takes it. A restart beat begins a new traversal and emits its first
// cell; an advance beat emits the next cell, or none once the traversal ends.
module spiral_order_address_generator_top
	import soag_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	soag_req_if.sink             req,
	soag_cell_if.source          coord,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata
);

	logic [SIZE_W-1:0] size_q;
	logic              corner_q;
	logic              dir_q;

	bound_t            top_q, bottom_q, left_q, right_q;
	bound_t            row_q, col_q;
	logic [1:0]        leg_q;
	logic [COUNT_W-1:0] count_q;
	logic              active_q;

	bound_t            nx_top, nx_bottom, nx_left, nx_right;
	logic [1:0]        nx_leg;
	logic [COUNT_W-1:0] nx_count;
	logic              nx_active;
	pos_t              nx_pos;

	logic [SIZE_W-1:0]   n;
	logic [2*SIZE_W-1:0] sq;
	logic [COUNT_W-1:0]  total;
	bound_t              n_m1;

	edge_t  edge_cur;
	logic   row_leg;
	logic   step_pos;
	bound_t lo, hi, cur, nxt;

	logic res_valid;
	logic res_last;
	logic accept;

	function automatic edge_t leg_edge(input logic dir, input logic [1:0] leg);
		edge_t e;
		if (!dir) begin
			unique case (leg)
				2'd0: e = EDGE_TOP;
				2'd1: e = EDGE_RIGHT;
				2'd2: e = EDGE_BOTTOM;
				default: e = EDGE_LEFT;
			endcase
		end else begin
			unique case (leg)
				2'd0: e = EDGE_LEFT;
				2'd1: e = EDGE_BOTTOM;
				2'd2: e = EDGE_RIGHT;
				default: e = EDGE_TOP;
			endcase
		end
		return e;
	endfunction

	function automatic pos_t enter_leg(input edge_t e, input logic fwd,
		input bound_t t, input bound_t b, input bound_t l, input bound_t r);
		pos_t p;
		unique case (e)
			EDGE_TOP: begin
				p.row = t;
				p.col = fwd ? l : r;
			end
			EDGE_BOTTOM: begin
				p.row = b;
				p.col = fwd ? l : r;
			end
			EDGE_RIGHT: begin
				p.col = r;
				p.row = fwd ? t : b;
			end
			default: begin
				p.col = l;
				p.row = fwd ? t : b;
			end
		endcase
		return p;
	endfunction

	assign n = (size_q == '0) ? SIZE_W'(1)
		: (size_q > SIZE_W'(MAX_SIZE)) ? SIZE_W'(MAX_SIZE) : size_q;
	assign sq    = n * n;
	assign total = sq[COUNT_W-1:0];
	assign n_m1  = $signed({1'b0, n}) - bound_t'(1);

	assign edge_cur = leg_edge(dir_q, leg_q);
	assign row_leg  = (edge_cur == EDGE_TOP) || (edge_cur == EDGE_BOTTOM);
	assign step_pos = !leg_q[1];
	assign lo       = row_leg ? left_q : top_q;
	assign hi       = row_leg ? right_q : bottom_q;
	assign cur      = row_leg ? col_q : row_q;
	assign nxt      = step_pos ? cur + bound_t'(1) : cur - bound_t'(1);

	always_comb begin
		nx_top    = top_q;
		nx_bottom = bottom_q;
		nx_left   = left_q;
		nx_right  = right_q;
		nx_leg    = leg_q;
		nx_count  = count_q;
		nx_active = active_q;
		nx_pos.row = row_q;
		nx_pos.col = col_q;
		res_valid = 1'b0;
		if (req.restart) begin
			nx_top    = '0;
			nx_left   = '0;
			nx_bottom = n_m1;
			nx_right  = n_m1;
			nx_leg    = corner_q ? 2'd2 : 2'd0;
			nx_pos    = enter_leg(leg_edge(dir_q, nx_leg), !nx_leg[1],
				nx_top, nx_bottom, nx_left, nx_right);
			nx_count  = COUNT_W'(1);
			nx_active = 1'b1;
			res_valid = 1'b1;
		end else if (active_q) begin
			if (count_q >= total) begin
				nx_active = 1'b0;
			end else if (nxt >= lo && nxt <= hi) begin
				if (row_leg) begin
					nx_pos.row = (edge_cur == EDGE_TOP) ? top_q : bottom_q;
					nx_pos.col = nxt;
				end else begin
					nx_pos.col = (edge_cur == EDGE_RIGHT) ? right_q : left_q;
					nx_pos.row = nxt;
				end
				nx_count  = count_q + COUNT_W'(1);
				res_valid = 1'b1;
			end else begin
				unique case (edge_cur)
					EDGE_TOP:    nx_top    = top_q + bound_t'(1);
					EDGE_RIGHT:  nx_right  = right_q - bound_t'(1);
					EDGE_BOTTOM: nx_bottom = bottom_q - bound_t'(1);
					default:     nx_left   = left_q + bound_t'(1);
				endcase
				nx_leg = leg_q + 2'd1;
				if (nx_top > nx_bottom || nx_left > nx_right) begin
					nx_active = 1'b0;
				end else begin
					nx_pos    = enter_leg(leg_edge(dir_q, nx_leg), !nx_leg[1],
						nx_top, nx_bottom, nx_left, nx_right);
					nx_count  = count_q + COUNT_W'(1);
					res_valid = 1'b1;
				end
			end
		end
		res_last = nx_count >= total;
		if (res_valid && res_last) begin
			nx_active = 1'b0;
		end
	end

	assign req.ready = !coord.valid || coord.ready;
	assign accept    = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q   <= SIZE_W'(8);
			corner_q <= 1'b0;
			dir_q    <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MATRIX_SIZE:    size_q   <= cfg_wdata;
				REG_START_CORNER:   corner_q <= cfg_wdata[0];
				REG_TURN_DIRECTION: dir_q    <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q    <= '0;
			bottom_q <= '0;
			left_q   <= '0;
			right_q  <= '0;
			row_q    <= '0;
			col_q    <= '0;
			leg_q    <= '0;
			count_q  <= '0;
			active_q <= 1'b0;
		end else if (accept) begin
			top_q    <= nx_top;
			bottom_q <= nx_bottom;
			left_q   <= nx_left;
			right_q  <= nx_right;
			row_q    <= nx_pos.row;
			col_q    <= nx_pos.col;
			leg_q    <= nx_leg;
			count_q  <= nx_count;
			active_q <= nx_active;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coord.valid <= 1'b0;
		end else if (accept) begin
			coord.valid <= res_valid;
		end else if (coord.ready) begin
			coord.valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && res_valid) begin
			coord.row          <= nx_pos.row[COORD_W-1:0];
			coord.column       <= nx_pos.col[COORD_W-1:0];
			coord.order_number <= nx_count;
			coord.last_cell    <= res_last;
		end
	end

`ifndef ASSERT_OFF
	a_last_ends_traversal: assert property (@(posedge clk) disable iff (!arst_n)
		accept && res_valid && res_last |=> !active_q)
		else $error("traversal still active after its last cell");

	a_restart_first_cell: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req.restart |=> coord.valid && coord.order_number == COUNT_W'(1))
		else $error("restart did not emit cell number one");

	a_active_has_count: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> count_q != '0)
		else $error("active traversal with zero cell count");

	a_cell_in_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		accept && res_valid |-> nx_pos.row >= nx_top && nx_pos.row <= nx_bottom
			&& nx_pos.col >= nx_left && nx_pos.col <= nx_right)
		else $error("emitted cell outside the current bounds");
`endif

endmodule
